/* sv/raster_window_fetch_padded_top_macros.svh */
// ----------------------------------------------------------------------------
// raster_window_fetch_padded_top_macros.svh
// Assertion macros used by the window fetch checker.
// ----------------------------------------------------------------------------
`ifndef RASTER_WINDOW_FETCH_PADDED_TOP_MACROS_SVH
`define RASTER_WINDOW_FETCH_PADDED_TOP_MACROS_SVH

// Check a property while out of reset.
`define RWF_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("window fetch check failed");

// Check a property at every edge, reset included.
`define RWF_CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("window fetch reset check failed");

`endif

/* sv/rwf_pkg.sv */
// ----------------------------------------------------------------------------
// rwf_pkg
// Word types, command codes and register indexes of the window fetch block.
// ----------------------------------------------------------------------------
package rwf_pkg;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
  localparam logic [1:0] REG_WINDOW_HALF  = 2'd2;

  localparam int CFG_DATA_BITS = 9;

  typedef struct packed {
    logic               command;
    logic [7:0]         row;
    logic [7:0]         column;
    logic signed [15:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] window_value;
    logic               is_outside;
    logic               last_of_window;
  } out_word_t;

  // One window position issued by the sequencer
  typedef struct packed {
    logic valid;
    logic outside;
    logic last;
  } issue_t;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_t;

endpackage

/* sv/rwf_store.sv */
// ----------------------------------------------------------------------------
// rwf_store
// Pixel memory: one write port, one read port with registered, held data.
// ----------------------------------------------------------------------------
module rwf_store #(
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 16
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data while the output word is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/rwf_seq.sv */
// ----------------------------------------------------------------------------
// rwf_seq
// Configuration registers, write decode and the window position sequencer.
// ----------------------------------------------------------------------------
module rwf_seq #(
  parameter int MAX_ROWS        = 256,
  parameter int MAX_COLUMNS     = 256,
  parameter int MAX_WINDOW_HALF = 3,
  parameter int ROW_BITS        = 8,
  parameter int COL_BITS        = 8,
  parameter int PIX_BITS        = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_write_en,
  input  logic [1:0]                           cfg_index,
  input  logic [rwf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 in_valid,
  input  rwf_pkg::in_word_t                    in_data,
  output logic                                 in_stall,
  input  logic                                 advance,
  output rwf_pkg::issue_t                      issue,
  output logic                                 rd_en,
  output logic [ROW_BITS+COL_BITS-1:0]         rd_addr,
  output logic                                 wr_en,
  output logic [ROW_BITS+COL_BITS-1:0]         wr_addr,
  output logic [PIX_BITS-1:0]                  wr_data
);

  localparam int HW = (MAX_WINDOW_HALF > 1) ? $clog2(MAX_WINDOW_HALF + 1) : 1;
  localparam int CW = HW + 1;

  logic [8:0]            row_count_r;
  logic [8:0]            column_count_r;
  logic [1:0]            window_half_r;

  rwf_pkg::seq_state_t   state_r, state_nxt;
  logic [7:0]            crow_r, crow_nxt;
  logic [7:0]            ccol_r, ccol_nxt;
  logic [HW-1:0]         half_r, half_nxt;
  logic [CW-1:0]         i_r, i_nxt;
  logic [CW-1:0]         j_r, j_nxt;

  logic [12:0]           rows_eff;
  logic [12:0]           cols_eff;
  logic [HW-1:0]         half_eff;
  logic [CW-1:0]         span;
  logic                  accept;
  logic signed [13:0]    pos_row;
  logic signed [13:0]    pos_col;
  logic                  row_in;
  logic                  col_in;
  logic [12:0]           wr_row_x;
  logic [12:0]           wr_col_x;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= 9'd256;
      column_count_r <= 9'd256;
      window_half_r  <= 2'd1;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        rwf_pkg::REG_ROW_COUNT:    row_count_r    <= cfg_data;
        rwf_pkg::REG_COLUMN_COUNT: column_count_r <= cfg_data;
        rwf_pkg::REG_WINDOW_HALF:  window_half_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign rows_eff = (13'(row_count_r) > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : 13'(row_count_r);
  assign cols_eff = (13'(column_count_r) > 13'(MAX_COLUMNS)) ?
                    13'(MAX_COLUMNS) : 13'(column_count_r);
  assign half_eff = (4'(window_half_r) > 4'(MAX_WINDOW_HALF)) ?
                    HW'(MAX_WINDOW_HALF) : HW'(window_half_r);

  assign in_stall = (state_r == rwf_pkg::SEQ_RUN);
  assign accept   = in_valid && !in_stall;

  // Pixel writes go straight to the store; drop those beyond the raster
  assign wr_row_x = 13'(in_data.row);
  assign wr_col_x = 13'(in_data.column);
  assign wr_en    = accept && (in_data.command == rwf_pkg::CMD_WRITE) &&
                    (wr_row_x < rows_eff) && (wr_col_x < cols_eff);
  assign wr_addr  = {wr_row_x[ROW_BITS-1:0], wr_col_x[COL_BITS-1:0]};
  assign wr_data  = in_data.pixel_value[PIX_BITS-1:0];

  // Shared position unit: centre plus offset, then bounds compare
  assign pos_row = $signed({6'd0, crow_r}) + $signed(14'(i_r)) - $signed(14'(half_r));
  assign pos_col = $signed({6'd0, ccol_r}) + $signed(14'(j_r)) - $signed(14'(half_r));
  assign row_in  = (pos_row >= 14'sd0) && (pos_row < $signed({1'b0, rows_eff}));
  assign col_in  = (pos_col >= 14'sd0) && (pos_col < $signed({1'b0, cols_eff}));
  assign span    = {half_r, 1'b0};

  assign issue.valid   = (state_r == rwf_pkg::SEQ_RUN);
  assign issue.outside = !(row_in && col_in);
  assign issue.last    = (i_r == span) && (j_r == span);

  assign rd_en   = issue.valid && advance;
  assign rd_addr = {pos_row[ROW_BITS-1:0], pos_col[COL_BITS-1:0]};

  always_comb begin
    state_nxt = state_r;
    crow_nxt  = crow_r;
    ccol_nxt  = ccol_r;
    half_nxt  = half_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    unique case (state_r)
      rwf_pkg::SEQ_IDLE: begin
        if (accept && (in_data.command == rwf_pkg::CMD_QUERY)) begin
          state_nxt = rwf_pkg::SEQ_RUN;
          crow_nxt  = in_data.row;
          ccol_nxt  = in_data.column;
          half_nxt  = half_eff;
          i_nxt     = '0;
          j_nxt     = '0;
        end
      end
      rwf_pkg::SEQ_RUN: begin
        // advance one position each time the output stage takes a word
        if (advance) begin
          if (j_r == span) begin
            j_nxt = '0;
            if (i_r == span) begin
              state_nxt = rwf_pkg::SEQ_IDLE;
            end else begin
              i_nxt = i_r + CW'(1);
            end
          end else begin
            j_nxt = j_r + CW'(1);
          end
        end
      end
      default: state_nxt = rwf_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rwf_pkg::SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crow_r <= crow_nxt;
    ccol_r <= ccol_nxt;
    half_r <= half_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
  end

endmodule

/* sv/raster_window_fetch_padded_top.sv */
// ----------------------------------------------------------------------------
// raster_window_fetch_padded_top
// Raster pixel store with padded square window readout.
// ----------------------------------------------------------------------------
// Write word: no result; the block stays ready for the next word.
// Query word: (2h+1)^2 result words, one per cycle while out_stall is low, set by
//   the single read port of the pixel memory. The first word passes the state and
//   output registers; in_stall holds until the last window position is issued.
// Reset (rst_n low, synchronous) restores the size registers and empties the
//   pipeline. The pixel memory is not cleared; unwritten pixels read undefined.
module raster_window_fetch_padded_top #(
  parameter int MAX_ROWS        = 256,
  parameter int MAX_COLUMNS     = 256,
  parameter int PIXEL_BITS      = 16,
  parameter int MAX_WINDOW_HALF = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_write_en,
  input  logic [1:0]                        cfg_index,
  input  logic [rwf_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rwf_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rwf_pkg::out_word_t                out_data
);

  localparam int ROW_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_BITS = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int PIX_BITS = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;
  localparam int AW       = ROW_BITS + COL_BITS;

  rwf_pkg::issue_t       issue;
  logic                  advance;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [PIX_BITS-1:0]   wr_data;
  logic [PIX_BITS-1:0]   rd_data;

  logic                  out_valid_r;
  logic                  outside_r;
  logic                  last_r;

  rwf_seq #(
    .MAX_ROWS        (MAX_ROWS),
    .MAX_COLUMNS     (MAX_COLUMNS),
    .MAX_WINDOW_HALF (MAX_WINDOW_HALF),
    .ROW_BITS        (ROW_BITS),
    .COL_BITS        (COL_BITS),
    .PIX_BITS        (PIX_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_data      (in_data),
    .in_stall     (in_stall),
    .advance      (advance),
    .issue        (issue),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  rwf_store #(
    .ADDR_BITS (AW),
    .DATA_BITS (PIX_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output stage: the memory read register carries the value, flags ride along
  assign advance = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= issue.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      outside_r <= issue.outside;
      last_r    <= issue.last;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_data.window_value   = outside_r ? 16'sd0 : 16'($signed(rd_data));
  assign out_data.is_outside     = outside_r;
  assign out_data.last_of_window = last_r;

endmodule

/* sv/rwf_checker.sv */
// ----------------------------------------------------------------------------
// rwf_checker
// Port-level checks of the window fetch block, bound to the top level.
// ----------------------------------------------------------------------------
`include "raster_window_fetch_padded_top_macros.svh"

module rwf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              cfg_write_en,
  input logic [1:0]                        cfg_index,
  input logic [rwf_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input logic                              in_valid,
  input logic                              in_stall,
  input rwf_pkg::in_word_t                 in_data,
  input logic                              out_valid,
  input logic                              out_stall,
  input rwf_pkg::out_word_t                out_data
);

  // a stalled result word holds
  `RWF_CHECK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))
  // padding positions carry zero
  `RWF_CHECK(a_pad_zero, out_valid && out_data.is_outside |-> out_data.window_value == 16'sd0)
  // busy only after an accepted query word
  `RWF_CHECK(a_busy_cause, $rose(in_stall) |-> $past(in_valid && !in_stall && (in_data.command == rwf_pkg::CMD_QUERY)))
  // busy ends exactly when the last window word appears
  `RWF_CHECK(a_busy_end, $fell(in_stall) |-> out_valid && out_data.last_of_window)
  // reset empties the block
  `RWF_CHECK_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && !in_stall)

endmodule

bind raster_window_fetch_padded_top rwf_checker u_rwf_checker (.*);
